@@ design/sapq_pkg.sv @@
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared constants and types for the sorted array priority queue: store
// depth, field widths, operation and status codes, and the command struct
// passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package sapq_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = 5;
   localparam int KEY_W  = 32;
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;

   // Response data word: found, key_out, count_out from bit 0 up, padded to bytes.
   localparam int RSP_BITS = 1 + KEY_W + CNT_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND    = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(DEPTH);

   typedef struct packed {
      logic exec;       // apply the presented item and load the response register
   } ctrl_cmd_type;

endpackage

@@ design/sapq_ctrl.sv @@
// ----------------------------------------------------------------------------
// sapq_ctrl
// Handshake controller: tracks whether the response register holds an item
// and decides when a request item is taken and executed.
// ----------------------------------------------------------------------------
module sapq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output sapq_pkg::ctrl_cmd_type cmd
);
   import sapq_pkg::*;

   localparam logic S_EMPTY = 1'b0;
   localparam logic S_HOLD  = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   // A new item may enter whenever the held response leaves in the same cycle.
   assign req_tready = (state_ff == S_EMPTY) || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_HOLD);
   assign cmd.exec   = accept;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_EMPTY: begin
            if (accept) state_in = S_HOLD;
         end
         S_HOLD: begin
            if (accept) state_in = S_HOLD;
            else if (rsp_tready) state_in = S_EMPTY;
         end
         default: state_in = S_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/sapq_datapath.sv @@
// ----------------------------------------------------------------------------
// sapq_datapath
// Row of key cells kept in ascending order, with one comparator per cell,
// the entry count, the limit register and the response register.
// ----------------------------------------------------------------------------
module sapq_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  sapq_pkg::ctrl_cmd_type        cmd,
   input  logic [sapq_pkg::CMD_W-1:0]    op,
   input  logic [sapq_pkg::KEY_W-1:0]    key,
   input  logic                          csr_we,
   input  logic [sapq_pkg::CNT_W-1:0]    csr_wdata,
   output logic [sapq_pkg::STAT_W-1:0]   status,
   output logic                          found,
   output logic [sapq_pkg::KEY_W-1:0]    key_out,
   output logic [sapq_pkg::CNT_W-1:0]    count_out
);
   import sapq_pkg::*;

   logic [KEY_W-1:0]  entry_ff [DEPTH];
   logic [KEY_W-1:0]  entry_in [DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  limit_ff;
   logic [CNT_W-1:0]  eff_limit;
   logic [CNT_W-1:0]  count_dec;
   logic [DEPTH-1:0]  at_or_after;
   logic [DEPTH-1:0]  hit;
   logic              is_full;
   logic              ins_do;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              found_ff, found_in;
   logic [KEY_W-1:0]  key_out_ff, key_out_in;
   logic [CNT_W-1:0]  count_out_ff;

   assign eff_limit = (limit_ff > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : limit_ff;
   assign is_full   = (count_ff >= eff_limit);
   assign count_dec = count_ff - CNT_W'(1);
   assign ins_do    = cmd.exec && (op == CMD_INSERT) && !is_full;

   // Cells past the count act as greater keys, so the marked run starts at the
   // insert position; the stored keys are sorted, so the run is contiguous.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (CNT_W'(i) < count_ff) begin
            at_or_after[i] = ($signed(entry_ff[i]) >= $signed(key));
            hit[i]         = (entry_ff[i] == key);
         end else begin
            at_or_after[i] = 1'b1;
            hit[i]         = 1'b0;
         end
      end
   end

   always_comb begin
      entry_in[0] = at_or_after[0] ? key : entry_ff[0];
      for (int i = 1; i < DEPTH; i++) begin
         if (at_or_after[i-1]) entry_in[i] = entry_ff[i-1];
         else if (at_or_after[i]) entry_in[i] = key;
         else entry_in[i] = entry_ff[i];
      end
   end

   always_comb begin
      count_in   = count_ff;
      status_in  = ST_OK;
      found_in   = 1'b0;
      key_out_in = '0;
      case (op)
         CMD_INSERT: begin
            if (is_full) status_in = ST_FULL;
            else count_in = count_ff + CNT_W'(1);
         end
         CMD_DEQUEUE: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               count_in   = count_dec;
               key_out_in = entry_ff[count_dec[IDX_W-1:0]];
            end
         end
         CMD_FIND: begin
            found_in = |hit;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ins_do) begin
         for (int i = 0; i < DEPTH; i++) entry_ff[i] <= entry_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         if (cmd.exec) count_ff <= count_in;
         if (csr_we) limit_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff    <= status_in;
         found_ff     <= found_in;
         key_out_ff   <= key_out_in;
         count_out_ff <= count_in;
      end
   end

   assign status    = status_ff;
   assign found     = found_ff;
   assign key_out   = key_out_ff;
   assign count_out = count_out_ff;

endmodule

@@ design/sorted_array_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Bounded priority queue holding signed Q16.16 keys in ascending order.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_) carries one item per operation: the operation
// in req_tuser (insert, dequeue largest, find) and the key in req_tdata.
// The response channel (rsp_) returns exactly one item per request: the
// status in rsp_tuser, and found, the dequeued key and the new count in
// rsp_tdata. The csr_ port writes the queue limit; the user must write it only
// while idle, as the block itself does not enforce this. Every cell compares
// its key with the request key in the same cycle, so the response is valid
// the cycle after the request is taken, and one item per cycle is sustained
// while the receiver keeps rsp_tready high. The response register frees
// itself in the cycle it is taken, so a new request is accepted in that
// same cycle. When the receiver stalls, the response is held and req_tready
// falls. Reset empties the queue, sets the limit to the full depth and drops
// rsp_tvalid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sapq_pkg::KEY_W-1:0]    req_tdata,   // [31:0] key
   input  logic [sapq_pkg::CMD_W-1:0]    req_tuser,   // [1:0] cmd
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [0] found, [32:1] key_out, [37:33] count_out, [39:38] zero
   output logic [sapq_pkg::RSP_W-1:0]    rsp_tdata,
   output logic [sapq_pkg::STAT_W-1:0]   rsp_tuser,   // [1:0] status
   input  logic                          csr_we,
   input  logic [sapq_pkg::CNT_W-1:0]    csr_wdata
);
   import sapq_pkg::*;

   ctrl_cmd_type     cmd;
   logic             found;
   logic [KEY_W-1:0] key_out;
   logic [CNT_W-1:0] count_out;

   sapq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   sapq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .op         (req_tuser),
      .key        (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .status     (rsp_tuser),
      .found      (found),
      .key_out    (key_out),
      .count_out  (count_out)
   );

   assign rsp_tdata = RSP_W'({count_out, key_out, found});

endmodule

@@ design/sapq_checker.sv @@
// ----------------------------------------------------------------------------
// sapq_checker
// Port-level checks for the sorted array priority queue, bound to the top.
// ----------------------------------------------------------------------------
module sapq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [sapq_pkg::RSP_W-1:0]    rsp_tdata,
   input logic [sapq_pkg::STAT_W-1:0]   rsp_tuser
);
   import sapq_pkg::*;

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

   // Every accepted item produces a response in the following cycle.
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no response one cycle after an accepted item");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1+KEY_W +: CNT_W] <= CNT_W'(DEPTH))
      else $error("reported count exceeds the depth");

   // A refused insert or dequeue returns neither a key nor a find hit.
   a_key_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_FULL || rsp_tuser == ST_EMPTY) |->
         rsp_tdata[KEY_W:1] == '0 && rsp_tdata[0] == 1'b0)
      else $error("refused operation returned a key or a find hit");

endmodule

bind sorted_array_priority_queue sapq_checker u_sapq_checker (.*);
